// ===== rtl/preemptive_priority_rr_scheduler_macros.svh =====
// Assertion macros for the priority round-robin scheduler.
// Used by the top level; no other dependencies.
`ifndef PREEMPTIVE_PRIORITY_RR_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_RR_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
// when a holds, c must hold in the same cycle
`define PPR_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("scheduler assertion failed");
// when a holds, c must hold in the next cycle
`define PPR_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("scheduler assertion failed");
`else
`define PPR_ASSERT_IMPL(lbl, a, c)
`define PPR_ASSERT_NEXT(lbl, a, c)
`endif
`endif

// ===== rtl/ppr_pkg.sv =====
// Shared types, status codes and defaults of the priority scheduler.
// No dependencies.
package ppr_pkg;
  localparam int DEPTH_DEFAULT  = 16;
  localparam int LEVELS_DEFAULT = 4;
  localparam logic [7:0] ADMIT_RESET = 8'd100;

  localparam logic [2:0] ST_LOAD_OK   = 3'd0;
  localparam logic [2:0] ST_LOAD_FULL = 3'd1;
  localparam logic [2:0] ST_RAN       = 3'd2;
  localparam logic [2:0] ST_IDLE      = 3'd3;
  localparam logic [2:0] ST_ALL_DONE  = 3'd4;

  typedef struct packed {
    logic [7:0]  name;
    logic [7:0]  arrival;
    logic [7:0]  runtime;
    logic [7:0]  left;
    logic        started;
    logic [15:0] first_run;
  } entry_t;

  typedef struct packed {
    logic        load;
    logic        run;
    logic        visit;
    logic        drain;
    logic [15:0] now;
    entry_t      load_entry;
  } level_cmd_t;

  typedef struct packed {
    logic   cand;
    logic   full;
    entry_t sel;
  } level_status_t;
endpackage

// ===== rtl/ppr_cell.sv =====
// One queue cell: holds a job entry, loads, shifts down from its neighbor
// or takes a run update. Depends on ppr_pkg.
module ppr_cell import ppr_pkg::*; (
  input  logic   clk,
  input  logic   load,
  input  logic   shift,
  input  logic   run,
  input  entry_t load_entry,
  input  entry_t shift_entry,
  input  entry_t run_entry,
  output entry_t entry
);
  // entry register, load wins over shift over run
  always_ff @(posedge clk) begin
    priority if (load) begin
      entry <= load_entry;
    end else if (shift) begin
      entry <= shift_entry;
    end else if (run) begin
      entry <= run_entry;
    end
  end
endmodule

// ===== rtl/ppr_level.sv =====
// One priority level: a chain of queue cells with fill count and
// round-robin pointer. Depends on ppr_pkg and ppr_cell.
module ppr_level import ppr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  level_cmd_t    cmd,
  output level_status_t stat
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CW-1:0] count;
  logic [PW-1:0] next;
  entry_t        cells [DEPTH];
  logic [DEPTH-1:0] elig;
  logic [PW-1:0] en;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos1;
  logic          elig_up;
  logic          finish;
  logic          full;
  entry_t        sel;
  entry_t        run_entry;

  // per-cell eligibility for the next turn
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      elig[k] = (CW'(k) < count) &&
                (cmd.drain ? cells[k].started : ({8'b0, cells[k].arrival} <= cmd.now));
    end
  end

  // pointer and selected entry
  assign en      = (CW'(next) >= count) ? '0 : next;
  assign pos     = cmd.drain ? (elig[next] ? next : '0) : en;
  assign pos1    = pos + PW'(1);
  assign elig_up = (pos != PW'(DEPTH - 1)) && elig[pos1];
  assign sel     = cells[pos];
  assign finish  = (sel.left <= 8'd1);
  assign full    = (count >= CW'(DEPTH));

  always_comb begin
    run_entry           = sel;
    run_entry.left      = sel.left - 8'd1;
    run_entry.started   = 1'b1;
    run_entry.first_run = sel.started ? sel.first_run : cmd.now;
  end

  // the cell chain
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    entry_t up;
    if (k < DEPTH - 1) begin : g_mid
      assign up = cells[k + 1];
    end else begin : g_end
      assign up = cells[k];
    end
    ppr_cell u_cell (
      .clk        (clk),
      .load       (cmd.load && !full && (CW'(k) == count)),
      .shift      (cmd.run && finish && (PW'(k) >= pos)),
      .run        (cmd.run && !finish && (PW'(k) == pos)),
      .load_entry (cmd.load_entry),
      .shift_entry(up),
      .run_entry  (run_entry),
      .entry      (cells[k])
    );
  end

  // fill count and round-robin pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      next  <= '0;
    end else begin
      if (cmd.load && !full) begin
        count <= count + CW'(1);
      end else if (cmd.run && finish) begin
        count <= count - CW'(1);
      end
      if (cmd.run) begin
        next <= elig_up ? (finish ? pos : pos1) : '0;
      end else if (cmd.visit) begin
        next <= en;
      end
    end
  end

  assign stat.cand = (count != '0) && (cmd.drain ? cells[0].started : elig[en]);
  assign stat.full = full;
  assign stat.sel  = sel;
endmodule

// ===== rtl/preemptive_priority_rr_scheduler.sv =====
// Top level of the preemptive priority round-robin scheduler.
// Depends on ppr_pkg, ppr_level, ppr_cell and the macros header.
//
// channel  signals                     direction  moves
// in       in_valid / in_stall         sink       one load or tick word
// out      out_valid / out_stall       source     one result word per item
// cfg      cfg_valid / cfg_ready       sink       admit_limit word
//
// An item is captured, then the level chains are scanned and updated
// as the result is registered.
// Reset is synchronous; the fill counts and pointers clear at once.
// A stalled output holds the next item in the capture register.
`include "preemptive_priority_rr_scheduler_macros.svh"
module preemptive_priority_rr_scheduler import ppr_pkg::*; #(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT,
  parameter int LEVELS      = LEVELS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  job_name,
  input  logic [7:0]  job_arrival,
  input  logic [7:0]  run_time,
  input  logic [2:0]  priority_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] slot_time,
  output logic [7:0]  ran_name,
  output logic        finished,
  output logic [15:0] response,
  output logic [15:0] turnaround,
  output logic [15:0] waiting,
  output logic [15:0] idle_total,
  output logic [7:0]  completed_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  localparam int LW = $clog2(LEVELS);

  logic        pend_valid;
  logic        pend_action;
  logic [7:0]  pend_name;
  logic [7:0]  pend_arrival;
  logic [7:0]  pend_runtime;
  logic [2:0]  pend_priority;
  logic [7:0]  admit_limit;
  logic [15:0] now_time;
  logic [15:0] idle_count;
  logic [7:0]  done_count;
  logic        process;
  logic        drain;
  logic [LW-1:0] load_lv;
  logic [LW-1:0] run_lv;
  logic        found;
  logic [LEVELS-1:0] visit;
  level_cmd_t    cmd  [LEVELS];
  level_status_t stat [LEVELS];
  entry_t      load_entry;
  entry_t      sel;
  logic [15:0] start_used;
  logic [15:0] resp_calc;
  logic [15:0] turn_calc;
  logic [15:0] wait_calc;
  logic        fin_calc;

  // capture stage
  assign in_stall  = pend_valid;
  assign process   = pend_valid && (!out_valid || !out_stall);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      pend_valid <= 1'b1;
    end else if (process) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pend_action   <= action;
      pend_name     <= job_name;
      pend_arrival  <= job_arrival;
      pend_runtime  <= run_time;
      pend_priority <= priority_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      admit_limit <= ADMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      admit_limit <= cfg_data;
    end
  end

  // level of a load: zero maps to the top, overflow to the bottom
  always_comb begin
    if (pend_priority == 3'd0) begin
      load_lv = '0;
    end else if ({1'b0, pend_priority} > 4'(LEVELS)) begin
      load_lv = LW'(LEVELS - 1);
    end else begin
      load_lv = LW'(pend_priority - 3'd1);
    end
  end

  assign drain = (now_time >= {8'b0, admit_limit});

  // highest candidate level; it and the levels scanned before it get a visit unless draining
  always_comb begin
    found  = 1'b0;
    run_lv = '0;
    for (int lv = 0; lv < LEVELS; lv++) begin
      visit[lv] = !drain && !found;
      if (!found && stat[lv].cand) begin
        found  = 1'b1;
        run_lv = LW'(lv);
      end
    end
  end

  always_comb begin
    load_entry.name      = pend_name;
    load_entry.arrival   = pend_arrival;
    load_entry.runtime   = pend_runtime;
    load_entry.left      = pend_runtime;
    load_entry.started   = 1'b0;
    load_entry.first_run = '0;
  end

  for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
    assign cmd[lv].load  = process && !pend_action && (load_lv == LW'(lv));
    assign cmd[lv].run   = process && pend_action && found && (run_lv == LW'(lv));
    assign cmd[lv].visit = process && pend_action && visit[lv];
    assign cmd[lv].drain = drain;
    assign cmd[lv].now   = now_time;
    assign cmd[lv].load_entry = load_entry;
    ppr_level #(.DEPTH(QUEUE_DEPTH)) u_level (
      .clk (clk),
      .rst (rst),
      .cmd (cmd[lv]),
      .stat(stat[lv])
    );
  end

  // metrics of the job that runs
  assign sel        = stat[run_lv].sel;
  assign fin_calc   = (sel.left <= 8'd1);
  assign start_used = sel.started ? sel.first_run : now_time;
  assign resp_calc  = start_used - {8'b0, sel.arrival};
  assign turn_calc  = now_time + {8'b0, sel.left} - {8'b0, sel.arrival};
  assign wait_calc  = turn_calc - {8'b0, sel.runtime};

  // time and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      now_time   <= '0;
      idle_count <= '0;
      done_count <= '0;
    end else if (process && pend_action) begin
      if ((found || !drain) && now_time != 16'hFFFF) begin
        now_time <= now_time + 16'd1;
      end
      if (!found && !drain && idle_count != 16'hFFFF) begin
        idle_count <= idle_count + 16'd1;
      end
      if (found && fin_calc && done_count != 8'hFF) begin
        done_count <= done_count + 8'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      slot_time  <= now_time;
      ran_name   <= '0;
      finished   <= 1'b0;
      response   <= '0;
      turnaround <= '0;
      waiting    <= '0;
      if (!pend_action) begin
        status <= stat[load_lv].full ? ST_LOAD_FULL : ST_LOAD_OK;
      end else if (found) begin
        status   <= ST_RAN;
        ran_name <= sel.name;
        if (fin_calc) begin
          finished   <= 1'b1;
          response   <= resp_calc;
          turnaround <= turn_calc;
          waiting    <= wait_calc;
        end
      end else begin
        status <= drain ? ST_ALL_DONE : ST_IDLE;
      end
    end
  end

  assign idle_total      = idle_count;
  assign completed_total = done_count;

  `PPR_ASSERT_NEXT(a_accept_pend, in_valid && !in_stall, pend_valid)
  `PPR_ASSERT_NEXT(a_process_out, process, out_valid)
  `PPR_ASSERT_NEXT(a_idle_mono, !process, $stable(idle_count) && $stable(now_time))
endmodule
